// ===== rtl/hbe_pkg.sv =====
package hbe_pkg;

   localparam int DATA_W      = 32;
   localparam int ACC_W       = 64;
   localparam int INDEX_W     = 4;
   localparam int FUNC_W      = 3;
   localparam int CFG_COUNT_W = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   localparam int MIN_BOUNDARIES = 2;

   localparam logic [FUNC_W-1:0] FUNC_WRITE       = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD         = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ_BUCKET = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_READ_ACC    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR       = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_CATEGORY_MODE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOUNDARY_COUNT = 2'd1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      OP_WRITE,
      OP_ADD,
      OP_READ_BUCKET,
      OP_READ_ACC,
      OP_CLEAR,
      OP_NOP,
      OP_REJECT
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [INDEX_W-1:0]        index;
      logic signed [DATA_W-1:0]  point;
      logic signed [DATA_W-1:0]  amount;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_LOW,
      ST_HIGH,
      ST_SEARCH,
      ST_CAT,
      ST_COUNT_WR,
      ST_READ,
      ST_EMIT
   } state_type;

endpackage

// ===== rtl/bucketed_histogram_engine.sv =====
// The back end handles one item at a time: writes, accumulator reads and rejected items go
// straight to the response, bucket reads read the count memory, a range add binary-searches the
// boundaries, a category add reads one boundary a cycle and a clear sweeps the count memory one
// entry a cycle. A two-entry queue lets requests be taken while it works.
// After reset a clearing pass zeroes the counts, with req_ready low.
module bucketed_histogram_engine import hbe_pkg::*; #(
   parameter int MAX_BOUNDARIES = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [FUNC_W-1:0]        req_func,
   input  logic [INDEX_W-1:0]       req_entry_index,
   input  logic signed [DATA_W-1:0] req_data_point,
   input  logic signed [DATA_W-1:0] req_amount,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_status,
   output logic signed [ACC_W-1:0]  rsp_read_value,
   output logic [INDEX_W-1:0]       rsp_hit_bucket,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data
);

   localparam int AW    = $clog2(MAX_BOUNDARIES);
   localparam int CNT_W = $clog2(MAX_BOUNDARIES + 1);

   logic                   mode_ff, mode_in;
   logic [CFG_COUNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0]       used_count, used_m1;
   logic [AW-1:0]          last_index;

   logic    q_push, q_pop, q_full, q_empty;
   cmd_type q_din, q_dout;
   logic    init_busy;

   assign csr_ready = 1'b1;

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CATEGORY_MODE: begin
               mode_in = csr_data[0];
            end
            CSR_BOUNDARY_COUNT: begin
               count_in = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         count_ff <= CFG_COUNT_W'(MIN_BOUNDARIES);
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

   // The programmed count is saturated to the range MIN_BOUNDARIES to MAX_BOUNDARIES.
   always_comb begin
      if (32'(count_ff) < MIN_BOUNDARIES) begin
         used_count = CNT_W'(MIN_BOUNDARIES);
      end else if (32'(count_ff) > MAX_BOUNDARIES) begin
         used_count = CNT_W'(MAX_BOUNDARIES);
      end else begin
         used_count = CNT_W'(count_ff);
      end
      used_m1    = used_count - CNT_W'(1);
      last_index = used_m1[AW-1:0];
   end

   hbe_front #(
      .MAX_BOUNDARIES (MAX_BOUNDARIES)
   ) u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_entry_index (req_entry_index),
      .req_data_point  (req_data_point),
      .req_amount      (req_amount),
      .used_count      (used_count),
      .init_busy       (init_busy),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_din           (q_din)
   );

   hbe_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_dout),
      .empty (q_empty)
   );

   hbe_back #(
      .MAX_BOUNDARIES (MAX_BOUNDARIES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .category_mode  (mode_ff),
      .last_index     (last_index),
      .q_empty        (q_empty),
      .q_dout         (q_dout),
      .q_pop          (q_pop),
      .init_busy      (init_busy),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_hit_bucket (rsp_hit_bucket)
   );

   // The back end must never take an entry from an empty queue.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("queue popped while empty");

   // No request may be taken while the post-reset clearing pass runs.
   assert property (@(posedge clock) disable iff (reset) init_busy |-> !req_ready)
      else $error("request taken during the clearing pass");

   // Straight after reset nothing is queued and no response is pending.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (!rsp_valid && q_empty))
      else $error("stale state after reset");

endmodule

// ===== rtl/hbe_front.sv =====
module hbe_front import hbe_pkg::*; #(
   parameter int MAX_BOUNDARIES = 16,
   localparam int CNT_W = $clog2(MAX_BOUNDARIES + 1)
) (
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [FUNC_W-1:0]        req_func,
   input  logic [INDEX_W-1:0]       req_entry_index,
   input  logic signed [DATA_W-1:0] req_data_point,
   input  logic signed [DATA_W-1:0] req_amount,
   input  logic [CNT_W-1:0]         used_count,
   input  logic                     init_busy,
   input  logic                     q_full,
   output logic                     q_push,
   output cmd_type                  q_din
);

   assign req_ready = !q_full && !init_busy;
   assign q_push    = req_valid && req_ready;

   // Index checks are settled here so that the back end only sees legal addresses.
   always_comb begin
      q_din.index  = req_entry_index;
      q_din.point  = req_data_point;
      q_din.amount = req_amount;
      case (req_func)
         FUNC_WRITE: begin
            q_din.op = (32'(req_entry_index) < MAX_BOUNDARIES) ? OP_WRITE : OP_REJECT;
         end
         FUNC_ADD: begin
            q_din.op = OP_ADD;
         end
         FUNC_READ_BUCKET: begin
            q_din.op = (32'(req_entry_index) < 32'(used_count)) ? OP_READ_BUCKET
                                                                  : OP_REJECT;
         end
         FUNC_READ_ACC: begin
            q_din.op = OP_READ_ACC;
         end
         FUNC_CLEAR: begin
            q_din.op = OP_CLEAR;
         end
         default: begin
            q_din.op = OP_NOP;
         end
      endcase
   end

endmodule

// ===== rtl/hbe_queue.sv =====
module hbe_queue import hbe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type din,
   output logic    full,
   input  logic    pop,
   output cmd_type dout,
   output logic    empty
);

   cmd_type                  slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]     fill_ff, fill_in;

   assign full  = (fill_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign empty = (fill_ff == '0);
   assign dout  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ===== rtl/hbe_back.sv =====
module hbe_back import hbe_pkg::*; #(
   parameter int MAX_BOUNDARIES = 16,
   localparam int AW = $clog2(MAX_BOUNDARIES)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    category_mode,
   input  logic [AW-1:0]           last_index,
   input  logic                    q_empty,
   input  cmd_type                 q_dout,
   output logic                    q_pop,
   output logic                    init_busy,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_status,
   output logic signed [ACC_W-1:0] rsp_read_value,
   output logic [INDEX_W-1:0]      rsp_hit_bucket
);

   localparam logic [AW-1:0] SWEEP_LAST = AW'(MAX_BOUNDARIES - 1);
   localparam logic [AW:0]   SPAN_ONE   = (AW+1)'(1);

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;

   logic [AW-1:0] lo_ff, lo_in;
   logic [AW-1:0] hi_ff, hi_in;
   logic [AW-1:0] mid_ff, mid_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic          sweep_rsp_ff, sweep_rsp_in;

   logic signed [ACC_W-1:0] prod_ff, prod_in;
   logic [ACC_W-1:0]        sum_ff, sum_in;

   logic                res_status_ff, res_status_in;
   logic [ACC_W-1:0]    res_value_ff, res_value_in;
   logic [INDEX_W-1:0]  res_hit_ff, res_hit_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_status_ff;
   logic [ACC_W-1:0]    rsp_value_ff;
   logic [INDEX_W-1:0]  rsp_hit_ff;
   logic                load_out;

   logic signed [DATA_W-1:0] bnd_mem_ff [MAX_BOUNDARIES];
   logic signed [DATA_W-1:0] bnd_rd_ff;
   logic                     bnd_we;
   logic [AW-1:0]            bnd_waddr, bnd_raddr;
   logic signed [DATA_W-1:0] bnd_wdata;

   logic [DATA_W-1:0]        cnt_mem_ff [MAX_BOUNDARIES];
   logic [DATA_W-1:0]        cnt_rd_ff;
   logic                     cnt_we;
   logic [AW-1:0]            cnt_waddr, cnt_raddr;
   logic [DATA_W-1:0]        cnt_wdata;

   logic [AW-1:0] step_lo, step_hi, step_mid, lo_next;
   logic [AW:0]   step_sum;
   logic          step_more;

   // One step of the binary search: the boundary read at mid has just arrived.
   always_comb begin
      if (bnd_rd_ff <= cmd_ff.point) begin
         step_lo = mid_ff;
         step_hi = hi_ff;
      end else begin
         step_lo = lo_ff;
         step_hi = mid_ff;
      end
      step_sum  = {1'b0, step_lo} + {1'b0, step_hi};
      step_mid  = step_sum[AW:1];
      step_more = ({1'b0, step_hi} - {1'b0, step_lo}) > SPAN_ONE;
      lo_next   = lo_ff + AW'(1);
   end

   assign init_busy = (state_ff == ST_SWEEP) && !sweep_rsp_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      sweep_in      = sweep_ff;
      sweep_rsp_in  = sweep_rsp_ff;
      prod_in       = prod_ff;
      sum_in        = sum_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_hit_in    = res_hit_ff;
      q_pop         = 1'b0;
      load_out      = 1'b0;
      bnd_we        = 1'b0;
      bnd_waddr     = AW'(q_dout.index);
      bnd_wdata     = q_dout.point;
      bnd_raddr     = '0;
      cnt_we        = 1'b0;
      cnt_waddr     = lo_ff;
      cnt_wdata     = '0;
      cnt_raddr     = lo_ff;

      case (state_ff)
         ST_SWEEP: begin
            cnt_we    = 1'b1;
            cnt_waddr = sweep_ff;
            if (sweep_ff == SWEEP_LAST) begin
               sweep_rsp_in = 1'b0;
               state_in     = sweep_rsp_ff ? ST_EMIT : ST_IDLE;
            end else begin
               sweep_in = sweep_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop         = 1'b1;
               cmd_in        = q_dout;
               res_status_in = 1'b0;
               res_value_in  = '0;
               res_hit_in    = '0;
               state_in      = ST_EMIT;
               case (q_dout.op)
                  OP_WRITE: begin
                     bnd_we = 1'b1;
                  end
                  OP_ADD: begin
                     prod_in   = q_dout.point * q_dout.amount;
                     lo_in     = '0;
                     bnd_raddr = '0;
                     state_in  = category_mode ? ST_CAT : ST_LOW;
                  end
                  OP_READ_BUCKET: begin
                     cnt_raddr = AW'(q_dout.index);
                     state_in  = ST_READ;
                  end
                  OP_READ_ACC: begin
                     res_value_in = sum_ff;
                  end
                  OP_CLEAR: begin
                     sum_in       = '0;
                     sweep_in     = '0;
                     sweep_rsp_in = 1'b1;
                     state_in     = ST_SWEEP;
                  end
                  OP_REJECT: begin
                     res_status_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOW: begin
            // Boundary 0 has arrived; fetch the top boundary in use next.
            if (bnd_rd_ff > cmd_ff.point) begin
               res_status_in = 1'b1;
               state_in      = ST_EMIT;
            end else begin
               bnd_raddr = last_index;
               state_in  = ST_HIGH;
            end
         end
         ST_HIGH: begin
            if (bnd_rd_ff < cmd_ff.point) begin
               res_status_in = 1'b1;
               state_in      = ST_EMIT;
            end else begin
               lo_in = '0;
               hi_in = last_index;
               if ({1'b0, last_index} > SPAN_ONE) begin
                  mid_in    = last_index >> 1;
                  bnd_raddr = last_index >> 1;
                  state_in  = ST_SEARCH;
               end else begin
                  cnt_raddr = '0;
                  state_in  = ST_COUNT_WR;
               end
            end
         end
         ST_SEARCH: begin
            lo_in = step_lo;
            hi_in = step_hi;
            if (step_more) begin
               mid_in    = step_mid;
               bnd_raddr = step_mid;
            end else begin
               cnt_raddr = step_lo;
               state_in  = ST_COUNT_WR;
            end
         end
         ST_CAT: begin
            // lo holds the entry whose boundary has just arrived.
            if (bnd_rd_ff == cmd_ff.point) begin
               cnt_raddr = lo_ff;
               state_in  = ST_COUNT_WR;
            end else if (lo_ff == last_index) begin
               res_status_in = 1'b1;
               state_in      = ST_EMIT;
            end else begin
               lo_in     = lo_next;
               bnd_raddr = lo_next;
            end
         end
         ST_COUNT_WR: begin
            cnt_we     = 1'b1;
            cnt_waddr  = lo_ff;
            cnt_wdata  = cnt_rd_ff + $unsigned(cmd_ff.amount);
            sum_in     = sum_ff + $unsigned(prod_ff);
            res_hit_in = INDEX_W'(lo_ff);
            state_in   = ST_EMIT;
         end
         ST_READ: begin
            res_value_in = {{(ACC_W-DATA_W){cnt_rd_ff[DATA_W-1]}}, cnt_rd_ff};
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         sweep_rsp_ff <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         sweep_rsp_ff <= sweep_rsp_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      prod_ff       <= prod_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_hit_ff    <= res_hit_in;
      if (load_out) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_hit_ff    <= res_hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (bnd_we) begin
         bnd_mem_ff[bnd_waddr] <= bnd_wdata;
      end
      bnd_rd_ff <= bnd_mem_ff[bnd_raddr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem_ff[cnt_waddr] <= cnt_wdata;
      end
      cnt_rd_ff <= cnt_mem_ff[cnt_raddr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_hit_bucket = rsp_hit_ff;

endmodule

// ===== sim/bucketed_histogram_engine_tb.sv =====
module bucketed_histogram_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hbe_pkg::*;

   localparam int BOUND_SLOTS  = 16;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int QUIET_CYCLES = 24;
   localparam int REPORT_LIMIT = 10;
   localparam int HOLD_CYCLES  = 400;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_MISS = 1'b1;

   localparam logic [FUNC_W-1:0] FUNC_FIRST_SPARE = FUNC_CLEAR + 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_LAST_SPARE  = '1;

   localparam logic signed [DATA_W-1:0] POINT_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] POINT_MAX = 32'sh7FFF_FFFF;

   typedef struct {
      logic [FUNC_W-1:0]        func;
      logic [INDEX_W-1:0]       entry;
      logic signed [DATA_W-1:0] point;
      logic signed [DATA_W-1:0] amount;
   } hist_item_type;

   typedef struct {
      logic               status;
      logic [ACC_W-1:0]   value;
      logic [INDEX_W-1:0] bucket;
   } hist_answer_type;

   typedef enum {BOUNDS_SPREAD, BOUNDS_TIGHT, BOUNDS_SCATTERED} bound_style_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [FUNC_W-1:0]        req_func = '0;
   logic [INDEX_W-1:0]       req_entry_index = '0;
   logic signed [DATA_W-1:0] req_data_point = '0;
   logic signed [DATA_W-1:0] req_amount = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_status;
   logic signed [ACC_W-1:0]  rsp_read_value;
   logic [INDEX_W-1:0]       rsp_hit_bucket;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_data = '0;

   bucketed_histogram_engine #(.MAX_BOUNDARIES(BOUND_SLOTS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_entry_index (req_entry_index),
      .req_data_point  (req_data_point),
      .req_amount      (req_amount),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_hit_bucket  (rsp_hit_bucket),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   // Shadow copy of the engine state, advanced as each request transfer happens.
   logic signed [DATA_W-1:0] shadow_bound [BOUND_SLOTS] = '{default: '0};
   logic [DATA_W-1:0]        shadow_count [BOUND_SLOTS] = '{default: '0};
   logic [ACC_W-1:0]         shadow_sum = '0;
   logic                     shadow_category = 1'b0;
   logic [CFG_COUNT_W-1:0]   shadow_nbound = CFG_COUNT_W'(MIN_BOUNDARIES);

   // Boundary values as they will stand once every queued write has gone through.
   logic signed [DATA_W-1:0] plan_bound [BOUND_SLOTS] = '{default: '0};

   hist_item_type   pending_items [$];
   hist_answer_type expected_answers [$];
   hist_item_type   offered;
   hist_answer_type want;

   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          rsp_hold = 1'b0;
   int          mismatch_count = 0;
   int unsigned cycle_count = 0;

   function automatic int used_bounds(input logic [CFG_COUNT_W-1:0] setting);
      if (setting < MIN_BOUNDARIES) return MIN_BOUNDARIES;
      if (setting > BOUND_SLOTS) return BOUND_SLOTS;
      return int'(setting);
   endfunction

   function automatic hist_answer_type histogram_answer(input hist_item_type it);
      hist_answer_type ans;
      int n, lo, hi, mid;
      logic found;
      ans = '{STATUS_OK, '0, '0};
      n = used_bounds(shadow_nbound);
      found = 1'b0;
      lo = 0;
      hi = n - 1;
      case (it.func)
         FUNC_WRITE: shadow_bound[it.entry] = it.point;
         FUNC_ADD: begin
            if (shadow_category) begin
               // Walking downwards leaves the lowest matching entry in lo.
               for (int i = n - 1; i >= 0; i--) begin
                  if (shadow_bound[i] == it.point) begin
                     lo = i;
                     found = 1'b1;
                  end
               end
            end else if (it.point >= shadow_bound[0] && it.point <= shadow_bound[n-1]) begin
               found = 1'b1;
               while (hi - lo > 1) begin
                  mid = (lo + hi) / 2;
                  if (shadow_bound[mid] <= it.point) lo = mid;
                  else hi = mid;
               end
            end
            if (found) begin
               shadow_count[lo] = shadow_count[lo] + it.amount;
               shadow_sum = shadow_sum + ACC_W'(longint'(it.point) * longint'(it.amount));
               ans.bucket = lo[INDEX_W-1:0];
            end else begin
               ans.status = STATUS_MISS;
            end
         end
         FUNC_READ_BUCKET: begin
            if (it.entry < n)
               ans.value = {{(ACC_W-DATA_W){shadow_count[it.entry][DATA_W-1]}},
                            shadow_count[it.entry]};
            else
               ans.status = STATUS_MISS;
         end
         FUNC_READ_ACC: ans.value = shadow_sum;
         FUNC_CLEAR: begin
            shadow_count = '{default: '0};
            shadow_sum = '0;
         end
         default: ;
      endcase
      return ans;
   endfunction

   task automatic flag_mismatch(input string what, input logic [ACC_W-1:0] expected,
                                input logic [ACC_W-1:0] actual);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t ns: %s mismatch: expected %h, got %h", $time, what, expected, actual);
   endtask

   // Request driver: a transfer is predicted at the edge where it happens.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            expected_answers.push_back(histogram_answer(offered));
         if (!req_valid || req_ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered = pending_items.pop_front();
               req_valid <= 1'b1;
               req_func <= offered.func;
               req_entry_index <= offered.entry;
               req_data_point <= offered.point;
               req_amount <= offered.amount;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_answers.size() == 0) begin
               flag_mismatch("unexpected response", '0, rsp_read_value);
            end else begin
               want = expected_answers.pop_front();
               if (rsp_status !== want.status)
                  flag_mismatch("status", ACC_W'(want.status), ACC_W'(rsp_status));
               if (rsp_read_value !== want.value)
                  flag_mismatch("read_value", want.value, rsp_read_value);
               if (rsp_hit_bucket !== want.bucket)
                  flag_mismatch("hit_bucket", ACC_W'(want.bucket), ACC_W'(rsp_hit_bucket));
            end
         end
         rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic queue_item(input logic [FUNC_W-1:0] func, input logic [INDEX_W-1:0] entry,
                             input logic signed [DATA_W-1:0] point,
                             input logic signed [DATA_W-1:0] amount);
      hist_item_type it;
      it = '{func, entry, point, amount};
      pending_items.push_back(it);
   endtask

   task automatic plan_write(input logic [INDEX_W-1:0] entry,
                             input logic signed [DATA_W-1:0] value);
      plan_bound[entry] = value;
      queue_item(FUNC_WRITE, entry, value, $urandom);
   endtask

   task automatic fill_bounds(input bound_style_type style);
      longint v, step_max;
      if (style == BOUNDS_SPREAD) begin
         v = longint'($urandom_range(32'h0800_0000)) - 64'sh8000_0000;
         step_max = 64'sh0FFF_FFFF;
      end else begin
         v = longint'($urandom_range(32'h8000_0000)) - 64'sh4000_0000;
         step_max = 3;
      end
      for (int i = 0; i < BOUND_SLOTS; i++) begin
         if (style == BOUNDS_SCATTERED) plan_write(INDEX_W'(i), $urandom);
         else plan_write(INDEX_W'(i), DATA_W'(v));
         v += longint'($urandom_range(int'(step_max)));
      end
   endtask

   // Mostly points on, next to or between the boundaries, so that adds hit buckets.
   function automatic logic signed [DATA_W-1:0] pick_point(input int n);
      int r;
      longint lo_b, span;
      r = $urandom_range(99);
      lo_b = plan_bound[0];
      span = longint'(plan_bound[n-1]) - lo_b;
      if (r < 40) return plan_bound[$urandom_range(n-1)];
      if (r < 58) return plan_bound[$urandom_range(n-1)] + ($urandom_range(1) ? 1 : -1);
      if (r < 75 && span > 0) return DATA_W'(lo_b + longint'($urandom) % (span + 1));
      if (r < 82) return plan_bound[n-1];
      if (r < 88) return plan_bound[0] - 1;
      if (r < 92) return plan_bound[n-1] + 1;
      if (r < 95) return $urandom_range(1) ? POINT_MIN : POINT_MAX;
      return $urandom;
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_amount();
      int r;
      r = $urandom_range(99);
      if (r < 30) return 1;
      if (r < 60) return $urandom_range(200) - 100;
      if (r < 92) return $urandom;
      return $urandom_range(1) ? POINT_MIN : POINT_MAX;
   endfunction

   task automatic wait_until_quiet();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_answers.size() != 0);
      // Leave the engine idle before the configuration changes.
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_CATEGORY_MODE) shadow_category = value[0];
      else if (index == CSR_BOUNDARY_COUNT) shadow_nbound = value[CFG_COUNT_W-1:0];
      @(negedge clock);
   endtask

   task automatic run_phase(input logic category, input logic [CFG_COUNT_W-1:0] nbound,
                            input int send_idle, input int recv_stall, input int n_items,
                            input bound_style_type style, input bit hold_rsp);
      int n, r;
      logic [INDEX_W-1:0] k;
      wait_until_quiet();
      write_csr(CSR_CATEGORY_MODE, CSR_DATA_W'(category));
      write_csr(CSR_BOUNDARY_COUNT, CSR_DATA_W'(nbound));
      send_idle_pct = send_idle;
      recv_stall_pct = recv_stall;
      n = used_bounds(nbound);
      rsp_hold = hold_rsp;
      fill_bounds(style);
      repeat (n_items) begin
         r = $urandom_range(99);
         k = INDEX_W'($urandom);
         if (r < 58)
            queue_item(FUNC_ADD, k, pick_point(n), pick_amount());
         else if (r < 72)
            queue_item(FUNC_READ_BUCKET, k, $urandom, $urandom);
         else if (r < 80)
            queue_item(FUNC_READ_ACC, k, $urandom, $urandom);
         else if (r < 83)
            queue_item(FUNC_CLEAR, k, $urandom, $urandom);
         else if (r < 94)
            plan_write(k, ($urandom_range(9) == 0) ? $urandom
                                                   : plan_bound[k] + $urandom_range(2) - 1);
         else
            queue_item(FUNC_W'($urandom_range(FUNC_LAST_SPARE, FUNC_FIRST_SPARE)), k,
                       $urandom, $urandom);
      end
      // With responses held back the engine fills up and must stall its request side.
      if (hold_rsp) begin
         repeat (HOLD_CYCLES) @(negedge clock);
         rsp_hold = 1'b0;
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // State straight after reset: two boundaries in use, counts swept to zero.
      queue_item(FUNC_READ_BUCKET, 4'd0, POINT_MAX, POINT_MIN);
      queue_item(FUNC_READ_BUCKET, 4'd2, '0, '0);
      queue_item(FUNC_READ_ACC, 4'd15, '1, '1);
      wait_until_quiet();

      write_csr(CSR_CATEGORY_MODE, '0);
      write_csr(CSR_BOUNDARY_COUNT, 5'd4);
      plan_write(4'd0, POINT_MIN);
      plan_write(4'd1, -32'sd5);
      plan_write(4'd2, 32'sd100);
      plan_write(4'd3, POINT_MAX - 32'sd1);
      plan_write(4'd15, 32'sh5A5A_A5A5);
      queue_item(FUNC_ADD, 4'd0, POINT_MIN, 32'sd1);
      // A point on the top boundary lands in the last range bucket, not above it.
      queue_item(FUNC_ADD, 4'd0, POINT_MAX - 32'sd1, POINT_MIN);
      queue_item(FUNC_ADD, 4'd0, 32'sd100, POINT_MAX);
      queue_item(FUNC_ADD, 4'd0, -32'sd5, -32'sd1);
      queue_item(FUNC_ADD, 4'd0, 32'sd99, 32'sd7);
      queue_item(FUNC_ADD, 4'd0, POINT_MAX, 32'sd3);
      queue_item(FUNC_READ_BUCKET, 4'd0, '0, '0);
      queue_item(FUNC_READ_BUCKET, 4'd3, '0, '0);
      queue_item(FUNC_READ_BUCKET, 4'd15, '0, '0);
      queue_item(FUNC_READ_ACC, 4'd0, '0, '0);
      queue_item(FUNC_FIRST_SPARE, 4'd15, POINT_MAX, POINT_MAX);
      queue_item(FUNC_LAST_SPARE, 4'd15, POINT_MIN, POINT_MIN);
      queue_item(FUNC_CLEAR, 4'd0, '0, '0);
      queue_item(FUNC_READ_ACC, 4'd0, '0, '0);
      queue_item(FUNC_READ_BUCKET, 4'd2, '0, '0);

      run_phase(1'b0, 5'd16, 0, 0, 110, BOUNDS_SPREAD, 1'b0);
      run_phase(1'b0, 5'd9, 0, 0, 90, BOUNDS_TIGHT, 1'b1);
      run_phase(1'b1, 5'd16, 88, 0, 80, BOUNDS_TIGHT, 1'b0);
      run_phase(1'b0, 5'd2, 0, 88, 80, BOUNDS_SPREAD, 1'b0);
      run_phase(1'b0, 5'd13, 37, 37, 90, BOUNDS_SPREAD, 1'b0);
      run_phase(1'b1, 5'd5, 0, 0, 90, BOUNDS_SCATTERED, 1'b0);
      // Counts outside the legal span are saturated by the engine.
      run_phase(1'b0, 5'd0, 37, 37, 80, BOUNDS_SPREAD, 1'b0);
      run_phase(1'b0, 5'd31, 0, 0, 90, BOUNDS_SCATTERED, 1'b0);
      run_phase(1'b1, 5'd2, 37, 37, 80, BOUNDS_TIGHT, 1'b0);
      wait_until_quiet();

      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
